// File: hdl/bdlp_pkg.sv
// bdlp_pkg: shared types, widths and register codes for the button debouncer
// no dependencies; imported by the interfaces and every module of the block
package bdlp_pkg;

  localparam int FIELD_W          = 3;
  localparam int DEBOUNCE_W       = 8;
  localparam int HOLD_W           = 16;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int NUM_BUTTONS_DEF  = 3;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 8'd2;
  localparam logic [HOLD_W-1:0]     LONG_PRESS_RST = 16'd60;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } cfg_reg_t;

  // what one lane reports for the current beat
  typedef struct packed {
    logic pressed;
    logic press_edge;
    logic release_edge;
    logic long_press;
  } lane_res_t;

  // one result beat
  typedef struct packed {
    logic [FIELD_W-1:0] pressed_flags;
    logic [FIELD_W-1:0] press_edges;
    logic [FIELD_W-1:0] release_edges;
    logic [FIELD_W-1:0] long_press_pulses;
  } res_t;

endpackage

// File: hdl/bdlp_if.sv
// bdlp_if: valid/ready channel interfaces for sample beats and result beats
// depends on bdlp_pkg for the field width
interface bdlp_in_if import bdlp_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pressed_flags;
  logic [FIELD_W-1:0] press_edges;
  logic [FIELD_W-1:0] release_edges;
  logic [FIELD_W-1:0] long_press_pulses;

  modport source (output valid, output pressed_flags, output press_edges,
                  output release_edges, output long_press_pulses, input ready);
  modport sink   (input valid, input pressed_flags, input press_edges,
                  input release_edges, input long_press_pulses, output ready);
endinterface

// File: hdl/bdlp_lane.sv
// bdlp_lane: debounce counters, hold counter and pressed flag of one button
// depends on bdlp_pkg for widths and the lane result struct
module bdlp_lane import bdlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  level,
  input  logic [DEBOUNCE_W-1:0] debounce_ticks,
  input  logic [HOLD_W-1:0]     long_press_ticks,
  output lane_res_t             res
);

  logic [DEBOUNCE_W-1:0] press_cnt_r, press_cnt_nxt;
  logic [DEBOUNCE_W-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [HOLD_W-1:0]     hold_r, hold_nxt, hold_base;
  logic                  pressed_r, pressed_nxt;

  always_comb begin
    press_cnt_nxt    = press_cnt_r;
    rel_cnt_nxt      = rel_cnt_r;
    pressed_nxt      = pressed_r;
    hold_base        = hold_r;
    res.press_edge   = 1'b0;
    res.release_edge = 1'b0;
    if (!level) begin
      rel_cnt_nxt = '0;
      if (press_cnt_r >= debounce_ticks) begin
        res.press_edge = !pressed_r;
        pressed_nxt    = 1'b1;
      end else begin
        press_cnt_nxt = press_cnt_r + 1'b1;
      end
    end else begin
      press_cnt_nxt = '0;
      hold_base     = '0;
      if (rel_cnt_r >= debounce_ticks) begin
        res.release_edge = pressed_r;
        pressed_nxt      = 1'b0;
      end else begin
        rel_cnt_nxt = rel_cnt_r + 1'b1;
      end
    end
    // hold count wraps at 16 bits
    hold_nxt       = pressed_nxt ? hold_base + 1'b1 : hold_base;
    res.long_press = pressed_nxt && (hold_nxt == long_press_ticks);
    res.pressed    = pressed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_cnt_r <= '0;
      rel_cnt_r   <= '0;
      hold_r      <= '0;
      pressed_r   <= 1'b0;
    end else if (step) begin
      press_cnt_r <= press_cnt_nxt;
      rel_cnt_r   <= rel_cnt_nxt;
      hold_r      <= hold_nxt;
      pressed_r   <= pressed_nxt;
    end
  end

endmodule

// File: hdl/bdlp_merge.sv
// bdlp_merge: packs lane results into result fields and buffers two result beats
// depends on bdlp_pkg for the lane and result structs
module bdlp_merge import bdlp_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lane_res_t lanes [NUM_BUTTONS],
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_data
);

  res_t       packed_res;
  res_t       slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  // lanes past the field width are dropped, missing lanes read as zero
  always_comb begin
    packed_res = '0;
    for (int j = 0; j < FIELD_W; j++) begin
      if (j < NUM_BUTTONS) begin
        packed_res.pressed_flags[j]     = lanes[j].pressed;
        packed_res.press_edges[j]       = lanes[j].press_edge;
        packed_res.release_edges[j]     = lanes[j].release_edge;
        packed_res.long_press_pulses[j] = lanes[j].long_press;
      end
    end
  end

  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          slot0_nxt = packed_res;
        end else begin
          slot1_nxt = packed_res;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        cnt_nxt   = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          slot0_nxt = packed_res;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = packed_res;
        end
      end
      2'b00: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// File: hdl/button_debounce_long_press.sv
// button_debounce_long_press: top level, configuration registers, lanes and merge
// depends on bdlp_pkg, bdlp_if, bdlp_lane and bdlp_merge
//
// one sample beat carries the raw active-low levels of the buttons; every beat
// yields exactly one result beat with the debounced pressed flags, one-beat
// press and release edges and a one-beat long-press pulse. each button has its
// own lane (press, release and 16-bit hold counters plus the pressed flag) and
// all lanes update in the same cycle the sample is accepted, so the block takes
// one sample per clock unless stalled. the result enters a two-entry output
// buffer in the cycle after acceptance; in_ch.ready drops only when both entries
// hold untaken results, so a stalled sink costs nothing until the buffer fills.
// a level must persist for more than debounce_ticks samples to flip the state;
// the long-press pulse fires when the hold count equals long_press_ticks and
// repeats every 65536 samples of one hold. cfg_index 0 is debounce_ticks,
// 1 is long_press_ticks; write only while no results are pending. lanes past
// the 3-bit fields see a pressed level and do not reach the outputs.
module button_debounce_long_press import bdlp_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bdlp_in_if.sink               in_ch,
  bdlp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [HOLD_W-1:0]     long_press_r;
  logic                  accept;
  logic                  in_ready;
  logic                  out_valid;
  res_t                  out_data;
  lane_res_t             lanes [NUM_BUTTONS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:   debounce_r   <= cfg_wdata[DEBOUNCE_W-1:0];
        REG_LONG_PRESS: long_press_r <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // one lane per button
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl;
    if (i < FIELD_W) begin : g_pin
      assign lvl = in_ch.button_levels[i];
    end else begin : g_none
      assign lvl = 1'b0;
    end
    bdlp_lane u_lane (
      .clk              (clk),
      .rst_n            (rst_n),
      .step             (accept),
      .level            (lvl),
      .debounce_ticks   (debounce_r),
      .long_press_ticks (long_press_r),
      .res              (lanes[i])
    );
  end

  // pack the lanes and buffer the result beats
  bdlp_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .lanes     (lanes),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.valid             = out_valid;
  assign out_ch.pressed_flags     = out_data.pressed_flags;
  assign out_ch.press_edges       = out_data.press_edges;
  assign out_ch.release_edges     = out_data.release_edges;
  assign out_ch.long_press_pulses = out_data.long_press_pulses;

`ifndef SYNTHESIS
  // a press edge always comes with the pressed flag set
  a_press_edge_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.press_edges & ~out_ch.pressed_flags) == '0))
    else $error("press edge without pressed flag");

  // a release edge always comes with the pressed flag clear
  a_release_edge_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.release_edges & out_ch.pressed_flags) == '0))
    else $error("release edge with pressed flag");

  // long press fires only while pressed
  a_long_press_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.long_press_pulses & ~out_ch.pressed_flags) == '0))
    else $error("long press while released");

  // an accepted sample shows up as a result beat on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> out_ch.valid)
    else $error("accepted sample produced no result beat");

  // ready drops only when the buffer holds results
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output buffer");
`endif

endmodule
